/* hw/rtl/lifo_stack_with_indexed_access_unit_defines.svh */
// Assertion macros for the stack RTL.
// Needs clk_i in the scope of each use, and rst_ni for LSIA_ASSERT; no other dependencies.
`ifndef LIFO_STACK_WITH_INDEXED_ACCESS_UNIT_DEFINES_SVH
`define LIFO_STACK_WITH_INDEXED_ACCESS_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define LSIA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lsia: assertion failed");
// Check a property on every clock edge, reset included
`define LSIA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("lsia: assertion failed");
`else
`define LSIA_ASSERT(lbl, prop)
`define LSIA_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

/* hw/rtl/lsia_pkg.sv */
// Types and codes for the LIFO stack with indexed access.
// No dependencies; used by lsia_cell and the top level.
package lsia_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned FILL_W = 7;

  typedef enum logic [1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_PEEK   = 2'd2,
    ACT_CHANGE = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_BADPOS    = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic              push;   // shift the stack down, value enters the top cell
    logic              pop;    // shift the stack up
    logic              load;   // copy stored words into the read lane
    logic              shift;  // advance read lane up and token down
    logic              start;  // launch the token at the top cell
    logic              wr;     // cell holding the token takes val
    logic [WORD_W-1:0] val;
  } cell_ctrl_t;

endpackage

/* hw/rtl/lsia_cell.sv */
// One stack cell: a stored word, a read-lane stage and a token stage.
// Depends on lsia_pkg; instantiated in a chain by the top level.
module lsia_cell
  import lsia_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctrl_t        ctrl_i,
  input  logic [WORD_W-1:0] up_data_i,   // word of the cell above
  input  logic [WORD_W-1:0] dn_data_i,   // word of the cell below
  input  logic [WORD_W-1:0] lane_dn_i,   // read lane of the cell below
  input  logic              tok_up_i,    // token of the cell above
  output logic [WORD_W-1:0] data_o,
  output logic [WORD_W-1:0] lane_o,
  output logic              tok_o
);

  logic [WORD_W-1:0] data_q, data_d;
  logic [WORD_W-1:0] lane_q, lane_d;
  logic              tok_q, tok_d;

  // Select the next stored word
  always_comb begin
    data_d = data_q;
    if (ctrl_i.push) begin
      data_d = up_data_i;
    end else if (ctrl_i.pop) begin
      data_d = dn_data_i;
    end else if (ctrl_i.wr && tok_q) begin
      data_d = ctrl_i.val;
    end
  end

  // Load or advance the read lane toward the top
  always_comb begin
    lane_d = lane_q;
    if (ctrl_i.load) begin
      lane_d = data_q;
    end else if (ctrl_i.shift) begin
      lane_d = lane_dn_i;
    end
  end

  // Pass the token one cell down per step
  assign tok_d = (ctrl_i.start || ctrl_i.shift) ? tok_up_i : tok_q;

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    lane_q <= lane_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign data_o = data_q;
  assign lane_o = lane_q;
  assign tok_o  = tok_q;

endmodule

/* hw/rtl/lifo_stack_with_indexed_access_unit.sv */
// LIFO stack of signed 32-bit words, STACK_DEPTH deep, built as a chain of cells with the
// top word in cell 0. One request is in flight at a time. Push, pop and any rejected request
// (full, empty, bad position) finish as soon as they are taken. For peek and change at position
// p, a read lane and a write token walk the cell chain one cell per cycle, so the position
// sets how long they take. A finished result waits in a holding register, so the next
// request is taken while the previous result is still on the output.
`include "lifo_stack_with_indexed_access_unit_defines.svh"
module lifo_stack_with_indexed_access_unit
  import lsia_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // [6:0] position, [38:7] value, [39] zero
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] action
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [31:0] read_data, [38:32] fill_count, [39] is_empty
  output logic [1:0]  m_axis_tuser_o    // [1:0] status
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_e;

  // Sequencer registers
  state_e            state_q, state_d;
  logic [POS_W-1:0]  walk_q, walk_d;
  act_e              op_q, op_d;
  logic [WORD_W-1:0] val_q, val_d;
  logic [CW-1:0]     cnt_q, cnt_d;

  // Holding and output registers
  logic              pend_v_q, pend_v_d;
  logic [WORD_W-1:0] pend_rd_q, pend_rd_d;
  status_e           pend_st_q, pend_st_d;
  logic [FILL_W-1:0] pend_fill_q, pend_fill_d;
  logic              pend_emp_q, pend_emp_d;
  logic              out_v_q, out_v_d;
  logic [39:0]       out_data_q, out_data_d;
  status_e           out_st_q, out_st_d;

  // Cell chain wiring
  cell_ctrl_t         ctrl;
  logic [WORD_W-1:0]  data_w [STACK_DEPTH];
  logic [WORD_W-1:0]  lane_w [STACK_DEPTH];
  logic [STACK_DEPTH-1:0] tok_w;

  // Request fields
  logic              in_acc;
  act_e              in_act;
  logic [POS_W-1:0]  in_pos;
  logic [WORD_W-1:0] in_val;
  logic              pos_bad;
  logic              res_set;
  logic [WORD_W-1:0] res_rd;
  status_e           res_st;
  logic [CW+FILL_W-1:0] cnt_wide;
  logic              out_load;

  assign s_axis_tready_o = (state_q == S_IDLE) && !pend_v_q;
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign in_act  = act_e'(s_axis_tuser_i);
  assign in_pos  = s_axis_tdata_i[POS_W-1:0];
  assign in_val  = s_axis_tdata_i[POS_W+WORD_W-1:POS_W];
  assign pos_bad = (in_pos == '0) || (PW'(in_pos) > PW'(cnt_q));

  // Sequence one request through the chain
  always_comb begin
    ctrl     = '0;
    ctrl.val = in_val;
    state_d  = state_q;
    walk_d   = walk_q;
    op_d     = op_q;
    val_d    = val_q;
    cnt_d    = cnt_q;
    res_set  = 1'b0;
    res_rd   = '0;
    res_st   = ST_OK;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_act)
            ACT_PUSH: begin
              res_set = 1'b1;
              if (cnt_q == CW'(STACK_DEPTH)) begin
                res_st = ST_FULL;
              end else begin
                ctrl.push = 1'b1;
                cnt_d     = cnt_q + 1'b1;
              end
            end
            ACT_POP: begin
              res_set = 1'b1;
              if (cnt_q == '0) begin
                res_st = ST_UNDERFLOW;
              end else begin
                ctrl.pop = 1'b1;
                res_rd   = data_w[0];
                cnt_d    = cnt_q - 1'b1;
              end
            end
            default: begin
              if (pos_bad) begin
                res_set = 1'b1;
                res_st  = ST_BADPOS;
              end else begin
                ctrl.load  = 1'b1;
                ctrl.start = 1'b1;
                walk_d     = in_pos - 1'b1;
                op_d       = in_act;
                val_d      = in_val;
                state_d    = S_WALK;
              end
            end
          endcase
        end
      end
      S_WALK: begin
        ctrl.val = val_q;
        if (walk_q == '0) begin
          res_set = 1'b1;
          if (op_q == ACT_PEEK) begin
            res_rd = lane_w[0];
          end else begin
            ctrl.wr = 1'b1;
          end
          state_d = S_IDLE;
        end else begin
          ctrl.shift = 1'b1;
          walk_d     = walk_q - 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Capture the result, then drain it to the output register
  assign cnt_wide = (CW + FILL_W)'(cnt_d);
  assign out_load = pend_v_q && (!out_v_q || m_axis_tready_i);

  always_comb begin
    pend_v_d    = pend_v_q;
    pend_rd_d   = pend_rd_q;
    pend_st_d   = pend_st_q;
    pend_fill_d = pend_fill_q;
    pend_emp_d  = pend_emp_q;
    out_v_d     = out_v_q;
    out_data_d  = out_data_q;
    out_st_d    = out_st_q;
    if (out_load) begin
      out_v_d    = 1'b1;
      out_data_d = {pend_emp_q, pend_fill_q, pend_rd_q};
      out_st_d   = pend_st_q;
      pend_v_d   = 1'b0;
    end else if (m_axis_tready_i) begin
      out_v_d = 1'b0;
    end
    if (res_set) begin
      pend_v_d    = 1'b1;
      pend_rd_d   = res_rd;
      pend_st_d   = res_st;
      pend_fill_d = cnt_wide[FILL_W-1:0];
      pend_emp_d  = (cnt_d == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      walk_q      <= '0;
      op_q        <= ACT_PUSH;
      val_q       <= '0;
      cnt_q       <= '0;
      pend_v_q    <= 1'b0;
      pend_rd_q   <= '0;
      pend_st_q   <= ST_OK;
      pend_fill_q <= '0;
      pend_emp_q  <= 1'b0;
      out_v_q     <= 1'b0;
      out_data_q  <= '0;
      out_st_q    <= ST_OK;
    end else begin
      state_q     <= state_d;
      walk_q      <= walk_d;
      op_q        <= op_d;
      val_q       <= val_d;
      cnt_q       <= cnt_d;
      pend_v_q    <= pend_v_d;
      pend_rd_q   <= pend_rd_d;
      pend_st_q   <= pend_st_d;
      pend_fill_q <= pend_fill_d;
      pend_emp_q  <= pend_emp_d;
      out_v_q     <= out_v_d;
      out_data_q  <= out_data_d;
      out_st_q    <= out_st_d;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_st_q;

  // Build the cell chain, top word in cell 0
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] up_data;
    logic [WORD_W-1:0] dn_data;
    logic [WORD_W-1:0] lane_dn;
    logic              tok_up;

    if (i == 0) begin : g_top
      assign up_data = ctrl.val;
      assign tok_up  = ctrl.start;
    end else begin : g_mid
      // Drop the token left by the previous walk when a new one starts
      assign up_data = data_w[i-1];
      assign tok_up  = tok_w[i-1] && !ctrl.start;
    end

    if (i == STACK_DEPTH - 1) begin : g_bot
      assign dn_data = '0;
      assign lane_dn = '0;
    end else begin : g_inner
      assign dn_data = data_w[i+1];
      assign lane_dn = lane_w[i+1];
    end

    lsia_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .up_data_i (up_data),
      .dn_data_i (dn_data),
      .lane_dn_i (lane_dn),
      .tok_up_i  (tok_up),
      .data_o    (data_w[i]),
      .lane_o    (lane_w[i]),
      .tok_o     (tok_w[i])
    );
  end

  // Checks on count, token and sequencing
  `LSIA_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CW'(STACK_DEPTH))
  `LSIA_ASSERT_ALWAYS(a_tok_single, $onehot0(tok_w))
  `LSIA_ASSERT(a_walk_no_pend, (state_q == S_WALK) |-> !pend_v_q)
  `LSIA_ASSERT(a_push_grows, (in_acc && in_act == ACT_PUSH && cnt_q != CW'(STACK_DEPTH)) |=> (cnt_q == $past(cnt_q) + 1'b1))

endmodule
